// ===== rtl/aovpbs_pkg.sv =====
// Shared widths, codes, state encoding and control structures of the AOV phase-bin statistic.
package aovpbs_pkg;

	localparam int TIME_W     = 48;
	localparam int MAG_W      = 24;
	localparam int FREQ_W     = 40;
	localparam int NBINS_W    = 5;
	localparam int F_W        = 48;
	localparam int PTS_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;
	localparam int FRAC_W     = 52;
	localparam int OPND_W     = 64;
	localparam int PROD_W     = 128;
	localparam int F_SHIFT    = 16;

	localparam int MUL_DIGIT_W = 4;
	localparam int MUL_STEPS   = OPND_W / MUL_DIGIT_W;
	localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
	localparam int DIV_STEPS   = PROD_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [FREQ_W-1:0]  FREQ_RESET  = 40'h01_0000_0000;
	localparam logic [MAG_W-1:0]   MEAN_RESET  = '0;
	localparam logic [NBINS_W-1:0] NBINS_RESET = 5'd10;
	localparam logic [F_W-1:0]     F_SAT       = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIAL_FREQ = 2'd0,
		CFG_MEAN_MAG   = 2'd1,
		CFG_NUM_BINS   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MS_PHASE = 3'd0,
		MS_SQ    = 3'd1,
		MS_DEV   = 3'd2,
		MS_SUM   = 3'd3,
		MS_NUM   = 3'd4,
		MS_DEN   = 3'd5
	} mul_sel_t;

	typedef enum logic [1:0] {
		DS_DEV = 2'd0,
		DS_SUM = 2'd1,
		DS_F   = 2'd2
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PH_WAIT,
		ST_BIN,
		ST_SQ_WAIT,
		ST_UPD,
		ST_RED_RD,
		ST_DEV_MUL,
		ST_DEV_MWAIT,
		ST_DEV_DIV,
		ST_DEV_DWAIT,
		ST_SUM_MWAIT,
		ST_SUM_DIV,
		ST_SUM_DWAIT,
		ST_FINAL,
		ST_NUM_WAIT,
		ST_DEN_WAIT,
		ST_F_WAIT,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic     accept;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     div_start;
		div_sel_t div_sel;
		logic     ld_bin;
		logic     upd;
		logic     ld_dev;
		logic     acc_s1;
		logic     acc_s2;
		logic     clr_bin;
		logic     ld_num;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic mul_busy;
		logic div_done;
		logic div_busy;
		logic last;
		logic full;
		logic bin_empty;
		logic idx_last;
		logic degenerate;
	} sts_t;

endpackage

// ===== rtl/aovpbs_sample_if.sv =====
// Sample channel: valid/ready handshake carrying one time and magnitude word.
interface aovpbs_sample_if;
	logic                                valid;
	logic                                ready;
	logic [aovpbs_pkg::TIME_W-1:0]       sample_time;
	logic signed [aovpbs_pkg::MAG_W-1:0] magnitude;
	logic                                last_sample;

	modport source(output valid, sample_time, magnitude, last_sample, input ready);
	modport sink(input valid, sample_time, magnitude, last_sample, output ready);
endinterface

// ===== rtl/aovpbs_result_if.sv =====
// Result channel: valid/ready handshake carrying one statistic word.
interface aovpbs_result_if;
	logic                           valid;
	logic                           ready;
	logic [aovpbs_pkg::F_W-1:0]     f_statistic;
	logic                           degenerate;
	logic [aovpbs_pkg::PTS_W-1:0]   points_used;

	modport source(output valid, f_statistic, degenerate, points_used, input ready);
	modport sink(input valid, f_statistic, degenerate, points_used, output ready);
endinterface

// ===== rtl/aovpbs_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying register index and data.
interface aovpbs_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [aovpbs_pkg::CFG_IDX_W-1:0]   index;
	logic [aovpbs_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/aov_phase_bin_statistic_core.sv =====
// Top level of the AOV phase-bin statistic: controller, datapath and channel hookup.
// The block computes the analysis-of-variance period statistic at one trial frequency.
// Each sample word is phased against the first time of the data set and folded into one
// of the phase bins; the word flagged last_sample closes the set, and one result word
// follows with the F statistic, the degenerate flag and the number of points used, after
// which all accumulators are clear for the next set. Samples are taken one at a time: a
// sample occupies the block until its two passes through the shared digit-serial
// multiplier, for the phase product and the squared magnitude, are done. A sample beyond
// MAX_POINTS skips both passes and is not accumulated. The last sample then starts the
// reduction over MAX_BINS bins: an empty bin is only cleared, a filled one takes two
// squarings in the multiplier and two divisions by the bin count in the shared restoring
// divider, and the final ratio takes two more multiplications and one division unless the
// result is degenerate. A finished result waits in an output register, so the next data
// set may start while it is still unread. Configuration writes are always accepted but
// must only be issued while the block is idle. The bins are flip-flops that reset clears
// at once, so no clearing pass follows reset.
module aov_phase_bin_statistic_core #(
	parameter int MAX_BINS   = 16,
	parameter int MAX_POINTS = 16384
) (
	input logic               clk,
	input logic               arst_n,
	aovpbs_sample_if.sink     sample,
	aovpbs_result_if.source   result,
	aovpbs_cfg_if.sink        cfg
);
	import aovpbs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Registers are plain flops, so a configuration word is always taken.
	assign cfg.ready = 1'b1;

	aovpbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	aovpbs_datapath #(
		.MAX_BINS   (MAX_BINS),
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg.valid & cfg.ready),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.smp_time   (sample.sample_time),
		.smp_mag    (sample.magnitude),
		.smp_last   (sample.last_sample),
		.res_f      (result.f_statistic),
		.res_degen  (result.degenerate),
		.res_points (result.points_used)
	);

	// A degenerate result always carries a zero statistic.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |-> result.f_statistic == '0)
		else $error("degenerate result with nonzero statistic");

	// The shared multiplier is never restarted while either arithmetic unit is working.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy && !sts.div_busy)
		else $error("multiplier started while an arithmetic unit is busy");

	// A new sample word is only taken once all arithmetic has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |-> !sts.mul_busy && !sts.div_busy)
		else $error("sample accepted during arithmetic");

	// A result word only appears after the controller loaded the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.out_load))
		else $error("result valid without a result load");
endmodule

// ===== rtl/aovpbs_mul.sv =====
// Digit-serial 64 x 64 multiplier, four multiplier bits per cycle, product held until restart.
module aovpbs_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [aovpbs_pkg::OPND_W-1:0]     a,
	input  logic [aovpbs_pkg::OPND_W-1:0]     b,
	output logic                              busy,
	output logic                              done,
	output logic [aovpbs_pkg::PROD_W-1:0]     prod
);
	import aovpbs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    a_q;
	logic [OPND_W-1:0]    b_q;
	logic [PROD_W-1:0]    acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Each step adds one partial product of the full multiplicand and one digit.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PROD_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + a_q * PROD_W'(b_q[MUL_DIGIT_W-1:0]);
			a_q   <= a_q << MUL_DIGIT_W;
			b_q   <= b_q >> MUL_DIGIT_W;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;
endmodule

// ===== rtl/aovpbs_div.sv =====
// Restoring 128 / 128 divider, one quotient bit per cycle, quotient held until restart.
module aovpbs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [aovpbs_pkg::PROD_W-1:0]  num,
	input  logic [aovpbs_pkg::PROD_W-1:0]  den,
	output logic                           busy,
	output logic                           done,
	output logic [aovpbs_pkg::PROD_W-1:0]  quo
);
	import aovpbs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W:0]      rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [PROD_W-1:0]    den_q;
	logic [PROD_W:0]      trial;
	logic                 fits;

	assign trial = {rem_q[PROD_W-1:0], quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top of quo_q while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== rtl/aovpbs_ctrl.sv =====
// Controller state machine sequencing accumulation, bin reduction and result delivery.
module aovpbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  aovpbs_pkg::sts_t  sts,
	output aovpbs_pkg::cmd_t  cmd
);
	import aovpbs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = MS_PHASE;
		cmd.div_sel  = DS_DEV;
		sample_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.full) begin
					state_d = sts.last ? ST_RED_RD : ST_IDLE;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_PHASE;
					state_d       = ST_PH_WAIT;
				end
			end
			ST_PH_WAIT: begin
				if (sts.mul_done) begin
					state_d = ST_BIN;
				end
			end
			ST_BIN: begin
				cmd.ld_bin    = 1'b1;
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_SQ;
				state_d       = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (sts.mul_done) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.last ? ST_RED_RD : ST_IDLE;
			end
			ST_RED_RD: begin
				if (sts.bin_empty) begin
					cmd.clr_bin = 1'b1;
					state_d     = sts.idx_last ? ST_FINAL : ST_RED_RD;
				end else begin
					cmd.ld_dev = 1'b1;
					state_d    = ST_DEV_MUL;
				end
			end
			ST_DEV_MUL: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_DEV;
				state_d       = ST_DEV_MWAIT;
			end
			ST_DEV_MWAIT: begin
				if (sts.mul_done) begin
					state_d = ST_DEV_DIV;
				end
			end
			ST_DEV_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_DEV;
				state_d       = ST_DEV_DWAIT;
			end
			ST_DEV_DWAIT: begin
				if (sts.div_done) begin
					cmd.acc_s1    = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_SUM;
					state_d       = ST_SUM_MWAIT;
				end
			end
			ST_SUM_MWAIT: begin
				if (sts.mul_done) begin
					state_d = ST_SUM_DIV;
				end
			end
			ST_SUM_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_SUM;
				state_d       = ST_SUM_DWAIT;
			end
			ST_SUM_DWAIT: begin
				if (sts.div_done) begin
					cmd.acc_s2  = 1'b1;
					cmd.clr_bin = 1'b1;
					state_d     = sts.idx_last ? ST_FINAL : ST_RED_RD;
				end
			end
			ST_FINAL: begin
				if (sts.degenerate) begin
					state_d = ST_OUT;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_NUM;
					state_d       = ST_NUM_WAIT;
				end
			end
			ST_NUM_WAIT: begin
				if (sts.mul_done) begin
					cmd.ld_num    = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_DEN;
					state_d       = ST_DEN_WAIT;
				end
			end
			ST_DEN_WAIT: begin
				if (sts.mul_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_F;
					state_d       = ST_F_WAIT;
				end
			end
			ST_F_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = res_valid_q;
endmodule

// ===== rtl/aovpbs_datapath.sv =====
// Datapath: configuration, bin accumulators, shared multiplier and divider, result register.
module aovpbs_datapath #(
	parameter int MAX_BINS   = 16,
	parameter int MAX_POINTS = 16384
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  aovpbs_pkg::cmd_t                      cmd,
	output aovpbs_pkg::sts_t                      sts,
	input  logic                                  cfg_we,
	input  logic [aovpbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aovpbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [aovpbs_pkg::TIME_W-1:0]         smp_time,
	input  logic signed [aovpbs_pkg::MAG_W-1:0]   smp_mag,
	input  logic                                  smp_last,
	output logic [aovpbs_pkg::F_W-1:0]            res_f,
	output logic                                  res_degen,
	output logic [aovpbs_pkg::PTS_W-1:0]          res_points
);
	import aovpbs_pkg::*;

	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int BW  = $clog2(MAX_BINS);
	localparam int RW  = $clog2(MAX_BINS + 1);
	localparam int SW  = MAG_W + CW;
	localparam int QW  = 2 * MAG_W - 2 + CW;
	localparam int DVW = SW + 1;

	logic [FREQ_W-1:0]       freq_q;
	logic signed [MAG_W-1:0] mean_q;
	logic [NBINS_W-1:0]      nbins_q;

	logic [TIME_W-1:0]       ref_q;
	logic                    have_ref_q;
	logic [CW-1:0]           pts_q;
	logic [TIME_W-1:0]       t_q;
	logic signed [MAG_W-1:0] m_q;
	logic                    last_q;
	logic [BW-1:0]           bin_q;
	logic [BW-1:0]           idx_q;
	logic signed [DVW-1:0]   dev_q;
	logic [OPND_W-1:0]       s1_q;
	logic [OPND_W-1:0]       s2_q;
	logic [PROD_W-1:0]       num_q;
	logic [F_W-1:0]          res_f_q;
	logic                    res_degen_q;
	logic [PTS_W-1:0]        res_pts_q;

	logic [CW-1:0]           cnt_q [MAX_BINS];
	logic signed [SW-1:0]    sum_q [MAX_BINS];
	logic [QW-1:0]           sq_q  [MAX_BINS];

	logic [RW-1:0]           r;
	logic [BW-1:0]           sel_idx;
	logic [CW-1:0]           cnt_sel;
	logic signed [SW-1:0]    sum_sel;
	logic [QW-1:0]           sq_sel;
	logic [MAG_W-1:0]        m_abs;
	logic [SW-1:0]           sum_abs;
	logic [DVW-1:0]          dev_abs;
	logic signed [DVW-1:0]   cnt_mean;
	logic [FRAC_W+RW-1:0]    frac_r;
	logic [RW-1:0]           bin_raw;
	logic [BW-1:0]           bin_idx;
	logic                    degen;

	logic [OPND_W-1:0]       mul_a;
	logic [OPND_W-1:0]       mul_b;
	logic [PROD_W-1:0]       prod;
	logic                    mul_busy;
	logic                    mul_done;
	logic [PROD_W-1:0]       div_num;
	logic [PROD_W-1:0]       div_den;
	logic [PROD_W-1:0]       quo;
	logic                    div_busy;
	logic                    div_done;

	// Bin count in use, clamped to the supported range.
	always_comb begin
		if (32'(nbins_q) < 2) begin
			r = RW'(2);
		end else if (32'(nbins_q) > MAX_BINS) begin
			r = RW'(MAX_BINS);
		end else begin
			r = RW'(nbins_q);
		end
	end

	assign sel_idx = cmd.upd ? bin_q : idx_q;
	assign cnt_sel = cnt_q[sel_idx];
	assign sum_sel = sum_q[sel_idx];
	assign sq_sel  = sq_q[sel_idx];

	assign m_abs    = m_q[MAG_W-1] ? $unsigned(-m_q) : $unsigned(m_q);
	assign sum_abs  = sum_sel[SW-1] ? $unsigned(-sum_sel) : $unsigned(sum_sel);
	assign dev_abs  = dev_q[DVW-1] ? $unsigned(-dev_q) : $unsigned(dev_q);
	assign cnt_mean = $signed({1'b0, cnt_sel}) * mean_q;

	// Phase bin: the fraction is the low bits of the phase product.
	assign frac_r  = (FRAC_W + RW)'(prod[FRAC_W-1:0]) * (FRAC_W + RW)'(r);
	assign bin_raw = frac_r[FRAC_W+RW-1:FRAC_W];
	assign bin_idx = (32'(bin_raw) >= MAX_BINS) ? BW'(MAX_BINS - 1) : BW'(bin_raw);

	assign degen = (s2_q == '0) || (32'(pts_q) <= 32'(r));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MS_PHASE: begin
				mul_a = OPND_W'(t_q) - OPND_W'(ref_q);
				mul_b = OPND_W'(freq_q);
			end
			MS_SQ: begin
				mul_a = OPND_W'(m_abs);
				mul_b = OPND_W'(m_abs);
			end
			MS_DEV: begin
				mul_a = OPND_W'(dev_abs);
				mul_b = OPND_W'(dev_abs);
			end
			MS_SUM: begin
				mul_a = OPND_W'(sum_abs);
				mul_b = OPND_W'(sum_abs);
			end
			MS_NUM: begin
				mul_a = s1_q;
				mul_b = OPND_W'(pts_q) - OPND_W'(r);
			end
			MS_DEN: begin
				mul_a = s2_q;
				mul_b = OPND_W'(r) - OPND_W'(1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		unique case (cmd.div_sel)
			DS_DEV, DS_SUM: begin
				div_num = prod;
				div_den = PROD_W'(cnt_sel);
			end
			DS_F: begin
				div_num = num_q;
				div_den = prod;
			end
			default: begin
				div_num = prod;
				div_den = PROD_W'(cnt_sel);
			end
		endcase
	end

	aovpbs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (prod)
	);

	aovpbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q  <= FREQ_RESET;
			mean_q  <= MEAN_RESET;
			nbins_q <= NBINS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TRIAL_FREQ: freq_q  <= cfg_data[FREQ_W-1:0];
				CFG_MEAN_MAG:   mean_q  <= cfg_data[MAG_W-1:0];
				CFG_NUM_BINS:   nbins_q <= cfg_data[NBINS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q      <= '0;
			have_ref_q <= 1'b0;
			pts_q      <= '0;
			idx_q      <= '0;
			s1_q       <= '0;
			s2_q       <= '0;
			for (int i = 0; i < MAX_BINS; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end else begin
			if (cmd.accept && !have_ref_q) begin
				ref_q      <= smp_time;
				have_ref_q <= 1'b1;
			end
			if (cmd.upd) begin
				cnt_q[sel_idx] <= cnt_sel + 1'b1;
				sum_q[sel_idx] <= sum_sel + SW'(m_q);
				sq_q[sel_idx]  <= sq_sel + QW'(prod);
				pts_q          <= pts_q + 1'b1;
			end
			if (cmd.acc_s1) begin
				s1_q <= s1_q + quo[OPND_W-1:0];
			end
			if (cmd.acc_s2) begin
				s2_q <= s2_q + OPND_W'(sq_sel) - quo[OPND_W-1:0];
			end
			if (cmd.clr_bin) begin
				cnt_q[sel_idx] <= '0;
				sum_q[sel_idx] <= '0;
				sq_q[sel_idx]  <= '0;
				idx_q <= (32'(idx_q) == MAX_BINS - 1) ? '0 : idx_q + 1'b1;
			end
			if (cmd.out_load) begin
				ref_q      <= '0;
				have_ref_q <= 1'b0;
				pts_q      <= '0;
				idx_q      <= '0;
				s1_q       <= '0;
				s2_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q    <= smp_time;
			m_q    <= smp_mag;
			last_q <= smp_last;
		end
		if (cmd.ld_bin) begin
			bin_q <= bin_idx;
		end
		if (cmd.ld_dev) begin
			dev_q <= DVW'(sum_sel) - cnt_mean;
		end
		if (cmd.ld_num) begin
			num_q <= prod << F_SHIFT;
		end
		if (cmd.out_load) begin
			res_degen_q <= degen;
			res_pts_q   <= PTS_W'(pts_q);
			if (degen) begin
				res_f_q <= '0;
			end else if (quo > PROD_W'(F_SAT)) begin
				res_f_q <= F_SAT;
			end else begin
				res_f_q <= quo[F_W-1:0];
			end
		end
	end

	assign sts.mul_done   = mul_done;
	assign sts.mul_busy   = mul_busy;
	assign sts.div_done   = div_done;
	assign sts.div_busy   = div_busy;
	assign sts.last       = last_q;
	assign sts.full       = 32'(pts_q) >= MAX_POINTS;
	assign sts.bin_empty  = cnt_sel == '0;
	assign sts.idx_last   = 32'(idx_q) == MAX_BINS - 1;
	assign sts.degenerate = degen;

	assign res_f      = res_f_q;
	assign res_degen  = res_degen_q;
	assign res_points = res_pts_q;
endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the AOV phase-bin statistic core.
`timescale 1ns / 1ps

module tb;
	import aovpbs_pkg::*;

	localparam int NBINS_MAX  = 16;
	localparam int POINTS_MAX = 16384;
	localparam int DOG_LIMIT  = 40000;
	localparam int SETTLE     = 200;

	typedef struct {
		logic [F_W-1:0]   f_stat;
		logic             degen;
		logic [PTS_W-1:0] points;
	} stat_word_t;

	logic clk = 1'b0;
	logic arst_n;

	aovpbs_sample_if s_if();
	aovpbs_result_if r_if();
	aovpbs_cfg_if    c_if();

	aov_phase_bin_statistic_core #(
		.MAX_BINS(NBINS_MAX),
		.MAX_POINTS(POINTS_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample(s_if),
		.result(r_if),
		.cfg(c_if)
	);

	// Shadow copy of the block's registers and accumulators.
	logic [FREQ_W-1:0]        freq_q;
	logic signed [MAG_W-1:0]  mean_q;
	logic [NBINS_W-1:0]       nbins_q;
	logic [TIME_W-1:0]        t0_q;
	bit                       have_t0;
	int                       pt_cnt;
	longint unsigned          bin_cnt [NBINS_MAX];
	longint                   bin_sum [NBINS_MAX];
	logic [63:0]              bin_sq  [NBINS_MAX];

	stat_word_t expected_stats[$];
	int errors;
	bit stall_en;
	int quiet_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic clear_bins();
		t0_q = '0;
		have_t0 = 1'b0;
		pt_cnt = 0;
		for (int i = 0; i < NBINS_MAX; i++) begin
			bin_cnt[i] = 0;
			bin_sum[i] = 0;
			bin_sq[i] = '0;
		end
	endtask

	// Folds one sample into the shadow bins; on the last sample the statistic is
	// reduced over every filled bin and the expected result word is queued.
	task automatic fold_sample(input logic [TIME_W-1:0] t, input logic signed [MAG_W-1:0] m,
			input logic last);
		int r;
		logic [63:0] dt, prod, binx;
		longint mm, dev, sabs;
		logic [127:0] w, num, den, q;
		logic [63:0] s1, s2;
		longint unsigned n;
		stat_word_t sw;
		r = int'(nbins_q);
		if (r < 2) r = 2;
		if (r > NBINS_MAX) r = NBINS_MAX;
		if (!have_t0) begin
			t0_q = t;
			have_t0 = 1'b1;
		end
		if (pt_cnt < POINTS_MAX) begin
			dt = {16'b0, t} - {16'b0, t0_q};
			prod = dt * {24'b0, freq_q};
			binx = ({12'b0, prod[FRAC_W-1:0]} * 64'(r)) >> FRAC_W;
			if (binx >= NBINS_MAX) binx = NBINS_MAX - 1;
			mm = m;
			bin_cnt[binx] += 1;
			bin_sum[binx] += mm;
			bin_sq[binx] += 64'(mm * mm);
			pt_cnt++;
		end
		if (!last) return;
		s1 = '0;
		s2 = '0;
		for (int i = 0; i < NBINS_MAX; i++) begin
			if (bin_cnt[i] == 0) continue;
			dev = bin_sum[i] - longint'(bin_cnt[i]) * longint'(mean_q);
			if (dev < 0) dev = -dev;
			w = 128'(dev) * 128'(dev);
			w = w / 128'(bin_cnt[i]);
			s1 += w[63:0];
			sabs = bin_sum[i] < 0 ? -bin_sum[i] : bin_sum[i];
			w = 128'(sabs) * 128'(sabs);
			w = w / 128'(bin_cnt[i]);
			s2 += bin_sq[i] - w[63:0];
		end
		n = pt_cnt;
		sw.degen = (s2 == 0) || (n <= r);
		sw.f_stat = '0;
		if (!sw.degen) begin
			num = (128'(s1) * 128'(n - r)) << F_SHIFT;
			den = 128'(s2) * 128'(r - 1);
			q = num / den;
			sw.f_stat = (q > 128'(F_SAT)) ? F_SAT : q[F_W-1:0];
		end
		sw.points = PTS_W'(n);
		expected_stats.push_back(sw);
		clear_bins();
	endtask

	// Presents one sample word; returns at the edge where it is taken, valid still high.
	task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [MAG_W-1:0] m,
			input logic last);
		@(negedge clk);
		if (stall_en && $urandom_range(0, 3) == 0) begin
			s_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_if.valid <= 1'b1;
		s_if.sample_time <= t;
		s_if.magnitude <= m;
		s_if.last_sample <= last;
		@(posedge clk);
		while (!s_if.ready) @(posedge clk);
		fold_sample(t, m, last);
	endtask

	// Drops sample valid and lets the block finish any sample still in flight.
	task automatic park_samples();
		@(negedge clk);
		s_if.valid <= 1'b0;
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic wait_drained();
		park_samples();
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		park_samples();
		@(negedge clk);
		c_if.valid <= 1'b1;
		c_if.index <= idx;
		c_if.data <= data;
		@(posedge clk);
		while (!c_if.ready) @(posedge clk);
		case (idx)
			CFG_TRIAL_FREQ: freq_q = data[FREQ_W-1:0];
			CFG_MEAN_MAG:   mean_q = data[MAG_W-1:0];
			CFG_NUM_BINS:   nbins_q = data[NBINS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		c_if.valid <= 1'b0;
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic signed [MAG_W-1:0] rand_mag();
		case ($urandom_range(0, 3))
			0: return MAG_W'($urandom);
			1: return MAG_W'($signed($urandom_range(0, 2000)) - 1000);
			default: return MAG_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	// One data set with mostly advancing times, now and then a jump to a random time, and random magnitudes.
	task automatic send_set(input int len);
		logic [TIME_W-1:0] t;
		t = rand48();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) t = rand48();
			else t = t + TIME_W'($urandom_range(0, 1 << 21));
			send_sample(t, rand_mag(), i == len - 1);
		end
	endtask

	// Default registers: a small set with full-range times, including a time before
	// the reference, which must wrap into the unit phase interval.
	task automatic test_defaults();
		send_sample(48'h0000_0100_0000, 24'sh7FFFFF, 1'b0);
		send_sample(48'h0, 24'sh800000, 1'b0);
		send_sample(48'hFFFF_FFFF_FFFF, 24'sh000001, 1'b0);
		for (int i = 0; i < 10; i++)
			send_sample(48'h0000_0100_0000 + 48'(i) * 48'h1_9999, rand_mag(), i == 9);
		wait_drained();
	endtask

	// Degenerate results: one point, too few points, and identical magnitudes.
	task automatic test_degenerate();
		send_sample(rand48(), rand_mag(), 1'b1);
		for (int i = 0; i < 10; i++) send_sample(48'(i) << 17, rand_mag(), i == 9);
		for (int i = 0; i < 14; i++) send_sample(48'(i) << 16, 24'sh012345, i == 13);
		wait_drained();
	endtask

	// Register extremes: bin counts outside the legal range clamp, frequency and
	// mean at both ends.
	task automatic test_reg_extremes();
		cfg_write(CFG_NUM_BINS, 40'd0);
		send_set(8);
		wait_drained();
		cfg_write(CFG_NUM_BINS, 40'd31);
		cfg_write(CFG_TRIAL_FREQ, 40'hFF_FFFF_FFFF);
		cfg_write(CFG_MEAN_MAG, 40'h80_0000);
		send_set(24);
		wait_drained();
		cfg_write(CFG_TRIAL_FREQ, 40'd0);
		cfg_write(CFG_MEAN_MAG, 40'h7F_FFFF);
		cfg_write(CFG_NUM_BINS, 40'd2);
		send_set(6);
		wait_drained();
		cfg_write(CFG_TRIAL_FREQ, 40'h01_0000_0000);
		cfg_write(CFG_MEAN_MAG, 40'd0);
		cfg_write(CFG_NUM_BINS, 40'd16);
	endtask

	// The bin count changes in the middle of a set; all filled bins still count.
	task automatic test_bins_midset();
		for (int i = 0; i < 8; i++) send_sample(48'(i) * 48'h2_0000, rand_mag(), 1'b0);
		cfg_write(CFG_NUM_BINS, 40'd3);
		for (int i = 0; i < 8; i++) send_sample(48'(i) * 48'h3_1000, rand_mag(), i == 7);
		wait_drained();
		cfg_write(CFG_NUM_BINS, 40'd10);
	endtask

	task automatic test_random();
		int sent;
		int len;
		sent = 0;
		stall_en = 1'b1;
		while (sent < 1500) begin
			if (sent > 1200) stall_en = 1'b0;
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				case ($urandom_range(0, 2))
					0: cfg_write(CFG_TRIAL_FREQ, 40'({$urandom, $urandom}));
					1: cfg_write(CFG_TRIAL_FREQ, 40'($urandom_range(1, 1 << 20)) << 24);
					default: cfg_write(CFG_TRIAL_FREQ, 40'($urandom));
				endcase
				cfg_write(CFG_MEAN_MAG, 40'(rand_mag()));
				cfg_write(CFG_NUM_BINS, 40'($urandom_range(0, 31)));
			end
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(3, 30);
			send_set(len);
			sent += len;
		end
		wait_drained();
	endtask

	// Result side: random stretches of back-pressure while stalling is on.
	initial begin
		r_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_en && $urandom_range(0, 5) == 0) begin
				r_if.ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				r_if.ready <= 1'b1;
			end
		end
	end

	// Every result word taken is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && r_if.valid && r_if.ready) begin
			if (expected_stats.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				stat_word_t e;
				e = expected_stats.pop_front();
				if (r_if.f_statistic !== e.f_stat)
					report($sformatf("f_statistic %0h, expected %0h", r_if.f_statistic,
						e.f_stat));
				if (r_if.degenerate !== e.degen)
					report($sformatf("degenerate %0b, expected %0b", r_if.degenerate, e.degen));
				if (r_if.points_used !== e.points)
					report($sformatf("points_used %0d, expected %0d", r_if.points_used,
						e.points));
			end
		end
	end

	// Watchdog: the run ends if no word moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_if.valid && s_if.ready) || (r_if.valid && r_if.ready) ||
				(c_if.valid && c_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= DOG_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", DOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		stall_en = 1'b1;
		arst_n = 1'b0;
		s_if.valid = 1'b0;
		s_if.sample_time = '0;
		s_if.magnitude = '0;
		s_if.last_sample = 1'b0;
		c_if.valid = 1'b0;
		c_if.index = CFG_TRIAL_FREQ;
		c_if.data = '0;
		freq_q = FREQ_RESET;
		mean_q = MEAN_RESET;
		nbins_q = NBINS_RESET;
		clear_bins();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_degenerate();
		test_reg_extremes();
		test_bins_midset();
		test_random();
		if (errors == 0 && expected_stats.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (expected_stats.size() != 0) report("expected results left over");
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
